FILE: src/integer_to_roman_encoder_unit_defines.svh
// Assertion macros used by the datapath of the integer to Roman numeral encoder.
`ifndef INTEGER_TO_ROMAN_ENCODER_UNIT_DEFINES_SVH
`define INTEGER_TO_ROMAN_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define I2R_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2R_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define I2R_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2R_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: src/i2r_pkg.sv
// Types, constants and lookup functions of the integer to Roman numeral encoder.
package i2r_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned CharW   = 7;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned LenW    = 3;
  localparam int unsigned ProdW   = 24;

  localparam logic [ValueW-1:0] MaxValue = 12'd3999;
  localparam logic [ValueW-1:0] Recip10  = 12'd3277;
  localparam int unsigned RecipShift     = 15;
  localparam int unsigned QuotW          = ProdW - RecipShift;

  localparam logic [CharW-1:0] ChrI = 7'h49;
  localparam logic [CharW-1:0] ChrV = 7'h56;
  localparam logic [CharW-1:0] ChrX = 7'h58;
  localparam logic [CharW-1:0] ChrL = 7'h4C;
  localparam logic [CharW-1:0] ChrC = 7'h43;
  localparam logic [CharW-1:0] ChrD = 7'h44;
  localparam logic [CharW-1:0] ChrM = 7'h4D;
  localparam logic [CharW-1:0] ChrNone = 7'h00;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLIT,
    S_EMIT,
    S_ERR
  } state_t;

  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_t;

  typedef struct packed {
    logic load;
    logic split;
    logic emit;
    logic put_err;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic split_done;
    logic slot_free;
    logic final_chr;
  } sts_t;

  function automatic logic [LenW-1:0] digit_len(input logic [DigitW-1:0] d);
    logic [LenW-1:0] n;
    unique case (d)
      4'd1, 4'd5:                n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9:    n = 3'd2;
      4'd3, 4'd7:                n = 3'd3;
      4'd8:                      n = 3'd4;
      default:                   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic sym_t digit_sym(input logic [DigitW-1:0] d,
                                     input logic [LenW-1:0] pos);
    sym_t s;
    priority if (d == 4'd9) begin
      s = (pos == 3'd0) ? SYM_ONE : SYM_TEN;
    end else if (d == 4'd4) begin
      s = (pos == 3'd0) ? SYM_ONE : SYM_FIVE;
    end else if (d >= 4'd5) begin
      s = (pos == 3'd0) ? SYM_FIVE : SYM_ONE;
    end else begin
      s = SYM_ONE;
    end
    return s;
  endfunction

  function automatic logic [CharW-1:0] place_letter(input logic [1:0] place,
                                                    input sym_t s);
    logic [CharW-1:0] c;
    unique case (place)
      2'd0: c = (s == SYM_ONE) ? ChrI : (s == SYM_FIVE) ? ChrV : ChrX;
      2'd1: c = (s == SYM_ONE) ? ChrX : (s == SYM_FIVE) ? ChrL : ChrC;
      2'd2: c = (s == SYM_ONE) ? ChrC : (s == SYM_FIVE) ? ChrD : ChrM;
      default: c = ChrM;
    endcase
    return c;
  endfunction

endpackage

FILE: src/i2r_if.sv
// Valid/ready channel interfaces for the encoder input values and output letters.
interface i2r_in_if;
  logic                      valid;
  logic                      ready;
  logic [i2r_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2r_out_if;
  logic                      valid;
  logic                      ready;
  logic [i2r_pkg::CharW-1:0] character;
  logic                      last;
  logic                      error;

  modport source (output valid, output character, output last, output error, input ready);
  modport sink   (input valid, input character, input last, input error, output ready);
endinterface

FILE: src/i2r_ctrl.sv
// Controller state machine that sequences digit splitting and letter output.
module i2r_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  i2r_pkg::sts_t sts,
  output i2r_pkg::cmd_t cmd
);
  import i2r_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = sts.bad ? S_ERR : S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (sts.split_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.slot_free && sts.final_chr) begin
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = accept;
      end
      S_SPLIT: cmd.split   = 1'b1;
      S_EMIT:  cmd.emit    = sts.slot_free;
      S_ERR:   cmd.put_err = sts.slot_free;
      default: cmd         = '0;
    endcase
  end

endmodule

FILE: src/i2r_datapath.sv
// Datapath with digit splitting, letter lookup and the output register.
`include "integer_to_roman_encoder_unit_defines.svh"

module i2r_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [i2r_pkg::ValueW-1:0] in_value,
  input  i2r_pkg::cmd_t              cmd,
  output i2r_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [i2r_pkg::CharW-1:0]  out_character,
  output logic                       out_last,
  output logic                       out_error
);
  import i2r_pkg::*;

  logic [ValueW-1:0] rem_r;
  logic [DigitW-1:0] digit_r [4];
  logic [1:0]        split_cnt_r;
  logic [1:0]        place_r;
  logic [LenW-1:0]   pos_r;

  logic              out_valid_r;
  logic [CharW-1:0]  out_chr_r;
  logic              out_last_r;
  logic              out_err_r;

  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot;
  logic [ValueW-1:0] quot_x10;
  logic [DigitW-1:0] split_digit;

  logic [DigitW-1:0] cur_digit;
  logic [LenW-1:0]   cur_len;
  logic              cur_end;
  logic              lower_zero;
  logic              emit_chr;
  logic [CharW-1:0]  cur_chr;

  assign prod        = ProdW'(rem_r) * ProdW'(Recip10);
  assign quot        = prod[ProdW-1:RecipShift];
  assign quot_x10    = ValueW'({quot, 3'b000}) + ValueW'({quot, 1'b0});
  assign split_digit = DigitW'(rem_r - quot_x10);

  assign cur_digit = digit_r[place_r];
  assign cur_len   = digit_len(cur_digit);
  assign cur_end   = (pos_r == cur_len - 3'd1);
  assign cur_chr   = place_letter(place_r, digit_sym(cur_digit, pos_r));
  assign emit_chr  = cmd.emit && (cur_len != '0);

  always_comb begin
    unique case (place_r)
      2'd3:    lower_zero = (digit_r[2] == '0) && (digit_r[1] == '0) && (digit_r[0] == '0);
      2'd2:    lower_zero = (digit_r[1] == '0) && (digit_r[0] == '0);
      2'd1:    lower_zero = (digit_r[0] == '0);
      default: lower_zero = 1'b1;
    endcase
  end

  assign sts.bad        = (in_value == '0) || (in_value > MaxValue);
  assign sts.split_done = (split_cnt_r == 2'd2);
  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.final_chr  = (cur_len != '0) && cur_end && lower_zero;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r       <= in_value;
      split_cnt_r <= 2'd0;
      place_r     <= 2'd3;
      pos_r       <= '0;
    end else if (cmd.split) begin
      rem_r                <= ValueW'(quot);
      digit_r[split_cnt_r] <= split_digit;
      split_cnt_r          <= split_cnt_r + 2'd1;
      if (split_cnt_r == 2'd2) begin
        digit_r[3] <= DigitW'(quot);
      end
    end else if (cmd.emit) begin
      if ((cur_len == '0) || cur_end) begin
        place_r <= place_r - 2'd1;
        pos_r   <= '0;
      end else begin
        pos_r <= pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_chr || cmd.put_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_err) begin
      out_chr_r  <= ChrNone;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end else if (emit_chr) begin
      out_chr_r  <= cur_chr;
      out_last_r <= cur_end && lower_zero;
      out_err_r  <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_chr_r;
  assign out_last      = out_last_r;
  assign out_error     = out_err_r;

  `I2R_ASSERT_NEVER(a_err_shape, clk, rst_n, out_valid_r && out_err_r && (!out_last_r || (out_chr_r != ChrNone)), "error transaction must be a single last item with zero character")
  `I2R_ASSERT_NEVER(a_letter_nonzero, clk, rst_n, out_valid_r && !out_err_r && (out_chr_r == ChrNone), "letter transaction carries no character")
  `I2R_ASSERT_NEVER(a_digit_range, clk, rst_n, cmd.emit && (cur_digit > 4'd9), "decimal digit out of range during output")
  `I2R_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_r && !out_ready) |-> !(emit_chr || cmd.put_err), "output register overwritten while stalled")

endmodule

FILE: src/integer_to_roman_encoder_unit.sv
// Top level of the integer to Roman numeral encoder.
//
// The in_chan channel takes one 12-bit unsigned value per transaction. The
// out_chan channel returns the numeral as one ASCII letter per transaction,
// most significant letter first, with last set on the final letter.
// A value of zero or above 3999 gives a single transaction with character 0,
// last 1 and error 1.
// A value is taken only while the unit is idle. After acceptance the digit
// splitter divides by ten with a reciprocal multiply, then letters leave at
// one per cycle while the receiver takes them, with a gap for each zero
// digit passed above the last nonzero one. The output register holds a
// letter until it is taken; while the receiver stalls, letter generation
// pauses and nothing is lost. A new value may be accepted while the last
// letter of the previous one still waits.
// Reset is synchronous and active low; it returns the unit to idle and
// empties the output register.
module integer_to_roman_encoder_unit (
  input logic      clk,
  input logic      rst_n,
  i2r_in_if.sink   in_chan,
  i2r_out_if.source out_chan
);
  import i2r_pkg::*;

  cmd_t cmd;
  sts_t sts;

  i2r_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2r_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_chan.value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_character (out_chan.character),
    .out_last      (out_chan.last),
    .out_error     (out_chan.error)
  );

endmodule
